// ===== src/ttd_pkg.sv =====
`default_nettype none

package ttd_pkg;

    // texel format codes
    localparam logic [2:0] FMT_I4    = 3'd0;
    localparam logic [2:0] FMT_I8    = 3'd1;
    localparam logic [2:0] FMT_IA4   = 3'd2;
    localparam logic [2:0] FMT_IA8   = 3'd3;
    localparam logic [2:0] FMT_C4    = 3'd4;
    localparam logic [2:0] FMT_C8    = 3'd5;
    localparam logic [2:0] FMT_C14X2 = 3'd6;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam int FMT_W      = 3;
    localparam int DIMREG_W   = 11;
    localparam int CFG_DATA_W = 11;
    localparam int HW_W       = 16;
    localparam int IDX_W      = 20;
    localparam int VAL_W      = 16;
    localparam int RUN_MAX    = 4;

    localparam int DEF_MAX_DIM = 1024;

    localparam logic [FMT_W-1:0]    RESET_FORMAT = FMT_I4;
    localparam logic [DIMREG_W-1:0] RESET_WIDTH  = 11'd8;
    localparam logic [DIMREG_W-1:0] RESET_HEIGHT = 11'd8;

    localparam logic [HW_W-1:0] C14_MASK = 16'h3FFF;
    localparam logic [3:0]      NIB_MASK = 4'hF;

endpackage

`default_nettype wire

// ===== src/tiled_texture_detiler_unit.sv =====
`default_nettype none

// channel    | direction | handshake              | payload
// -----------+-----------+------------------------+-------------------------------------
// source     | in        | src_valid / src_stall   | src_halfword
// texel      | out       | texel_valid / texel_stall | texel_index, texel_value,
//            |           |                        | run_last, image_last
// config     | in        | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one texel leaves per cycle while texel_stall is low; a source request yields 4 texels (I4, C4),
// 2 (I8, C8, IA4) or 1 (IA8, C14X2), and each run drains through the single texel output register;
// one request may sit in the input register while the previous run drains
// reset clears position, format (I4) and dimensions (8 x 8); config is always ready
// a stalled texel holds; source stall rises only when the input register is full
// and its run cannot move on

module tiled_texture_detiler_unit #(
    parameter int MAX_DIM = ttd_pkg::DEF_MAX_DIM
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           src_valid,
    output logic                                src_stall,
    input  wire logic [ttd_pkg::HW_W-1:0]       src_halfword,

    output logic                                texel_valid,
    input  wire logic                           texel_stall,
    output logic [ttd_pkg::IDX_W-1:0]           texel_index,
    output logic [ttd_pkg::VAL_W-1:0]           texel_value,
    output logic                                run_last,
    output logic                                image_last,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ttd_pkg::CFG_DATA_W-1:0] cfg_data
);

    // rounded dimension needs room for MAX_DIM plus up to one tile of padding
    localparam int DIM_W  = $clog2(MAX_DIM + 8);
    localparam int TILE_W = DIM_W - 2;
    localparam int CMP_W  = (DIM_W > ttd_pkg::DIMREG_W) ? DIM_W : ttd_pkg::DIMREG_W;
    localparam int PROD_W = 2 * DIM_W;
    localparam int SUM_W  = (PROD_W + 1 > ttd_pkg::IDX_W) ? PROD_W + 1 : ttd_pkg::IDX_W;

    // configuration registers
    logic [ttd_pkg::FMT_W-1:0]    format_reg;
    logic [ttd_pkg::DIMREG_W-1:0] width_reg;
    logic [ttd_pkg::DIMREG_W-1:0] height_reg;

    // tiled position of the next source request
    logic [TILE_W-1:0] tile_col_reg, tile_col_next;
    logic [TILE_W-1:0] tile_row_reg, tile_row_next;
    logic [2:0]        row_in_tile_reg, row_in_tile_next;
    logic [1:0]        hw_in_row_reg, hw_in_row_next;

    // input register
    logic                         in_valid_reg;
    logic [ttd_pkg::HW_W-1:0]     in_hw_reg;
    logic [ttd_pkg::FMT_W-1:0]    in_fmt_reg;
    logic [ttd_pkg::IDX_W-1:0]    in_index_reg;
    logic                         in_img_end_reg;

    // texel output register (run of up to four texels)
    logic                         busy_reg;
    logic [1:0]                   remain_reg;
    logic [ttd_pkg::IDX_W-1:0]    index_reg;
    logic [ttd_pkg::VAL_W-1:0]    vals_reg [ttd_pkg::RUN_MAX];
    logic                         img_end_reg;

    // geometry for the current format
    logic       fmt_ok;
    logic [1:0] tw_shift;
    logic [3:0] th;
    logic [1:0] per_shift;
    logic [2:0] hw_per_row;

    logic [CMP_W-1:0]  w_ext, h_ext, max_ext;
    logic [DIM_W-1:0]  w_clamp, h_clamp;
    logic [DIM_W-1:0]  tw_mask, th_mask;
    logic [DIM_W-1:0]  w_act, h_act;
    logic [DIM_W-1:0]  tiles_x_full, tiles_y_full;
    logic [TILE_W-1:0] tiles_x, tiles_y;

    logic [DIM_W-1:0]  x0, y0;
    logic [PROD_W-1:0] row_base;
    logic [SUM_W-1:0]  idx_sum;

    logic hw_end, row_end, col_end, trow_end, img_end;

    logic src_take, run_last_now, emit, run_free, in_move;

    logic [ttd_pkg::VAL_W-1:0] dec_vals [ttd_pkg::RUN_MAX];
    logic [1:0]                dec_cnt;

    assign cfg_ready = 1'b1;

    // format geometry decoder
    always_comb
    begin
        fmt_ok     = 1'b1;
        tw_shift   = 2'd3;
        th         = 4'd8;
        per_shift  = 2'd2;
        hw_per_row = 3'd2;
        unique case (format_reg) inside
            ttd_pkg::FMT_I4, ttd_pkg::FMT_C4:
            begin
                tw_shift   = 2'd3;
                th         = 4'd8;
                per_shift  = 2'd2;
                hw_per_row = 3'd2;
            end
            ttd_pkg::FMT_I8, ttd_pkg::FMT_C8, ttd_pkg::FMT_IA4:
            begin
                tw_shift   = 2'd3;
                th         = 4'd4;
                per_shift  = 2'd1;
                hw_per_row = 3'd4;
            end
            ttd_pkg::FMT_IA8, ttd_pkg::FMT_C14X2:
            begin
                tw_shift   = 2'd2;
                th         = 4'd4;
                per_shift  = 2'd0;
                hw_per_row = 3'd4;
            end
            default:
            begin
                // unused code: request is swallowed, position holds
                fmt_ok = 1'b0;
            end
        endcase
    end

    // clamp zero to one and oversize to MAX_DIM, then round up to whole tiles
    always_comb
    begin
        w_ext   = CMP_W'(width_reg);
        h_ext   = CMP_W'(height_reg);
        max_ext = CMP_W'(MAX_DIM);

        if (w_ext == '0)
            w_clamp = DIM_W'(1);
        else if (w_ext > max_ext)
            w_clamp = max_ext[DIM_W-1:0];
        else
            w_clamp = w_ext[DIM_W-1:0];

        if (h_ext == '0)
            h_clamp = DIM_W'(1);
        else if (h_ext > max_ext)
            h_clamp = max_ext[DIM_W-1:0];
        else
            h_clamp = h_ext[DIM_W-1:0];

        tw_mask = (DIM_W'(1) << tw_shift) - DIM_W'(1);
        th_mask = DIM_W'(th) - DIM_W'(1);
        w_act   = (w_clamp + tw_mask) & ~tw_mask;
        h_act   = (h_clamp + th_mask) & ~th_mask;

        tiles_x_full = w_act >> tw_shift;
        tiles_y_full = (th == 4'd8) ? (h_act >> 3) : (h_act >> 2);
        tiles_x      = tiles_x_full[TILE_W-1:0];
        tiles_y      = tiles_y_full[TILE_W-1:0];
    end

    // linear index of the first texel of this request
    always_comb
    begin
        x0 = (DIM_W'(tile_col_reg) << tw_shift)
           + (DIM_W'(hw_in_row_reg) << per_shift);
        y0 = ((th == 4'd8) ? (DIM_W'(tile_row_reg) << 3) : (DIM_W'(tile_row_reg) << 2))
           + DIM_W'(row_in_tile_reg);
        row_base = PROD_W'(y0) * PROD_W'(w_act);
        idx_sum  = SUM_W'(row_base) + SUM_W'(x0);
    end

    // position walk: halfword within row, row within tile, tile column, tile row
    always_comb
    begin
        hw_end   = ({1'b0, hw_in_row_reg} + 3'd1) >= hw_per_row;
        row_end  = ({1'b0, row_in_tile_reg} + 4'd1) >= th;
        col_end  = ({1'b0, tile_col_reg} + (TILE_W + 1)'(1)) >= {1'b0, tiles_x};
        trow_end = ({1'b0, tile_row_reg} + (TILE_W + 1)'(1)) >= {1'b0, tiles_y};
        img_end  = hw_end && row_end && col_end && trow_end;

        hw_in_row_next   = hw_in_row_reg;
        row_in_tile_next = row_in_tile_reg;
        tile_col_next    = tile_col_reg;
        tile_row_next    = tile_row_reg;

        if (hw_end)
        begin
            hw_in_row_next = '0;
            if (row_end)
            begin
                row_in_tile_next = '0;
                if (col_end)
                begin
                    tile_col_next = '0;
                    tile_row_next = trow_end ? '0 : tile_row_reg + TILE_W'(1);
                end
                else
                begin
                    tile_col_next = tile_col_reg + TILE_W'(1);
                end
            end
            else
            begin
                row_in_tile_next = row_in_tile_reg + 3'd1;
            end
        end
        else
        begin
            hw_in_row_next = hw_in_row_reg + 2'd1;
        end
    end

    // handshake: the input register moves on when no run is busy or as the last texel of a run leaves
    assign run_last_now = (remain_reg == 2'd0);
    assign emit         = busy_reg && !texel_stall;
    assign run_free     = !busy_reg || (emit && run_last_now);
    assign in_move      = in_valid_reg && run_free;
    assign src_stall    = in_valid_reg && !run_free;
    assign src_take     = src_valid && !src_stall;

    // texel value expansion for the request in the input register
    always_comb
    begin
        for (int k = 0; k < ttd_pkg::RUN_MAX; k++)
        begin
            dec_vals[k] = '0;
        end
        dec_cnt = 2'd0;
        case (in_fmt_reg)
            ttd_pkg::FMT_I4:
            begin
                for (int k = 0; k < ttd_pkg::RUN_MAX; k++)
                begin
                    dec_vals[k] = {8'd0, in_hw_reg[15 - 4*k -: 4], in_hw_reg[15 - 4*k -: 4]};
                end
                dec_cnt = 2'd3;
            end
            ttd_pkg::FMT_C4:
            begin
                for (int k = 0; k < ttd_pkg::RUN_MAX; k++)
                begin
                    dec_vals[k] = {12'd0, in_hw_reg[15 - 4*k -: 4] & ttd_pkg::NIB_MASK};
                end
                dec_cnt = 2'd3;
            end
            ttd_pkg::FMT_I8, ttd_pkg::FMT_C8:
            begin
                dec_vals[0] = {8'd0, in_hw_reg[15:8]};
                dec_vals[1] = {8'd0, in_hw_reg[7:0]};
                dec_cnt     = 2'd1;
            end
            ttd_pkg::FMT_IA4:
            begin
                // high nibble to the low byte, low nibble to the high byte
                dec_vals[0] = {in_hw_reg[11:8], in_hw_reg[11:8],
                               in_hw_reg[15:12], in_hw_reg[15:12]};
                dec_vals[1] = {in_hw_reg[3:0], in_hw_reg[3:0],
                               in_hw_reg[7:4], in_hw_reg[7:4]};
                dec_cnt     = 2'd1;
            end
            ttd_pkg::FMT_IA8:
            begin
                dec_vals[0] = {in_hw_reg[7:0], in_hw_reg[15:8]};
            end
            ttd_pkg::FMT_C14X2:
            begin
                dec_vals[0] = in_hw_reg & ttd_pkg::C14_MASK;
            end
            default:
            begin
                dec_cnt = 2'd0;
            end
        endcase
    end

    // configuration and position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg      <= ttd_pkg::RESET_FORMAT;
            width_reg       <= ttd_pkg::RESET_WIDTH;
            height_reg      <= ttd_pkg::RESET_HEIGHT;
            tile_col_reg    <= '0;
            tile_row_reg    <= '0;
            row_in_tile_reg <= '0;
            hw_in_row_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ttd_pkg::REG_FORMAT: format_reg <= cfg_data[ttd_pkg::FMT_W-1:0];
                ttd_pkg::REG_WIDTH:  width_reg  <= cfg_data[ttd_pkg::DIMREG_W-1:0];
                ttd_pkg::REG_HEIGHT: height_reg <= cfg_data[ttd_pkg::DIMREG_W-1:0];
                default:             ;
            endcase
            // any write starts a new image
            tile_col_reg    <= '0;
            tile_row_reg    <= '0;
            row_in_tile_reg <= '0;
            hw_in_row_reg   <= '0;
        end
        else if (src_take && fmt_ok)
        begin
            tile_col_reg    <= tile_col_next;
            tile_row_reg    <= tile_row_next;
            row_in_tile_reg <= row_in_tile_next;
            hw_in_row_reg   <= hw_in_row_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (src_take && fmt_ok)
            in_valid_reg <= 1'b1;
        else if (in_move)
            in_valid_reg <= 1'b0;
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (src_take && fmt_ok)
        begin
            in_hw_reg      <= src_halfword;
            in_fmt_reg     <= format_reg;
            in_index_reg   <= idx_sum[ttd_pkg::IDX_W-1:0];
            in_img_end_reg <= img_end;
        end
    end

    // output run control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            remain_reg <= '0;
        end
        else if (in_move)
        begin
            busy_reg   <= 1'b1;
            remain_reg <= dec_cnt;
        end
        else if (emit)
        begin
            if (run_last_now)
                busy_reg <= 1'b0;
            else
                remain_reg <= remain_reg - 2'd1;
        end
    end

    // output run payload: index steps and values shift down as texels leave
    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            index_reg   <= in_index_reg;
            img_end_reg <= in_img_end_reg;
            for (int k = 0; k < ttd_pkg::RUN_MAX; k++)
            begin
                vals_reg[k] <= dec_vals[k];
            end
        end
        else if (emit && !run_last_now)
        begin
            index_reg <= index_reg + ttd_pkg::IDX_W'(1);
            for (int k = 0; k < ttd_pkg::RUN_MAX - 1; k++)
            begin
                vals_reg[k] <= vals_reg[k+1];
            end
        end
    end

    assign texel_valid = busy_reg;
    assign texel_index = index_reg;
    assign texel_value = vals_reg[0];
    assign run_last    = run_last_now;
    assign image_last  = run_last_now && img_end_reg;

endmodule

`default_nettype wire
